// ----- design/svst_pkg.sv -----
// Shared constants, types and helper functions of the sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none

package svst_pkg;

    // Default values of the top-level parameters.
    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF  = 16;

    // Width of the rotation datapath (Q2.30 plus guard bits).
    localparam int CW     = 34;
    // Number of entries in the arctangent table.
    localparam int ATAN_N = 24;
    // Quotient bits of the disk radius divider.
    localparam int QB     = 23;
    // Width of the divider remainder.
    localparam int RW     = 35;

    localparam logic [CW-1:0]     CORDIC_GAIN  = 34'd652032874;
    localparam logic signed [23:0] Q716_MAX    = 24'sd8388607;
    localparam logic [22:0]       RADIUS_RESET = 23'd117965;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CENTRE_X = 2'd0,
        REG_CENTRE_Y = 2'd1,
        REG_CENTRE_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    // Arctangent of 2^-i in a 2^32-per-turn angle.
    localparam logic [31:0] ATAN_TABLE [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Data carried by one pipeline stage; each stage uses the part it needs.
    typedef struct packed {
        logic [2:0][CW-1:0] cx;
        logic [2:0][CW-1:0] cy;
        logic [2:0][CW-1:0] cz;
        logic [2:0][1:0]    quad;
        logic [5:0][15:0]   trig;
        logic [15:0]        nx;
        logic [15:0]        ny;
        logic [15:0]        nz;
        logic [23:0]        px;
        logic [23:0]        py;
        logic [23:0]        pz;
        logic [RW-1:0]      rem;
        logic [16:0]        den;
        logic [QB-1:0]      quo;
        logic               clip;
        logic               neg;
        logic               lu;
        logic               lv;
        logic [23:0]        du;
        logic [23:0]        dv;
    } stage_t;

    // Arctangent step i extended to the datapath width.
    function automatic logic [CW-1:0] atan_step(input int i);
        return {2'b00, ATAN_TABLE[i]};
    endfunction

    // Saturate a wide signed value to 16 bits.
    function automatic logic [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            return 16'h7FFF;
        else if (v < -48'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    // Saturate a wide signed value to 24 bits.
    function automatic logic [23:0] sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607)
            return 24'h7FFFFF;
        else if (v < -48'sd8388608)
            return 24'h800000;
        else
            return v[23:0];
    endfunction

    // Round away 15 fraction bits: add half, then floor.
    function automatic logic signed [47:0] rnd15(input logic signed [47:0] v);
        return (v + 48'sd16384) >>> 15;
    endfunction

endpackage

`default_nettype wire

// ----- design/svst_in_if.sv -----
// Input channel of the sphere vertex generator: one sample point per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface svst_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] colatitude;
    logic [15:0] longitude;
    logic        local_u;
    logic        local_v;

    modport source (output valid, colatitude, longitude, local_u, local_v, input ready);
    modport sink   (input valid, colatitude, longitude, local_u, local_v, output ready);
endinterface

`default_nettype wire

// ----- design/svst_out_if.sv -----
// Output channel of the sphere vertex generator: one vertex per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface svst_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] pos_z;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [23:0] disk_u;
    logic [23:0] disk_v;
    logic        tex_local_u;
    logic        tex_local_v;
    logic        disk_saturated;

    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    disk_u, disk_v, tex_local_u, tex_local_v, disk_saturated,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    disk_u, disk_v, tex_local_u, tex_local_v, disk_saturated,
                    output ready);
endinterface

`default_nettype wire

// ----- design/sphere_vertex_stereo_texcoord.sv -----
// Sphere vertex generator: position, normal and stereographic disk coordinate.
//
// Usage: each transfer on vin carries a colatitude and a longitude in binary
// angle units plus two local texture bits. Each transfer on vout carries the
// vertex position (centre + radius * normal, Q7.16), the unit normal (Q1.15),
// the disk texture coordinate (Q7.16) with its clip flag, and the two bits.
// The centre and radius are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no vertex is in flight (the block does not enforce it).
// The pipeline has one entry stage, one stage per rotation step for three
// rotation units, trig rounding, normal products, position, 23 divider stages
// and the disk output stage. Every stage holds a valid bit.
// Throughput is one vertex per cycle while the receiver is ready.
// Reset clears all valid bits and loads the centre to zero and radius to 1.8.
// When the receiver stalls, a stage only holds while the stage after it is
// full, so bubbles are squeezed out and vin stays ready until the whole
// pipeline is full; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module sphere_vertex_stereo_texcoord #(
    parameter int ANGLE_BITS      = svst_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = svst_pkg::TRIG_ITER_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    svst_in_if.sink           vin,
    svst_out_if.source        vout
);
    import svst_pkg::*;

    // Stage map.
    localparam int S_TRIG  = TRIG_ITERATIONS + 1;
    localparam int S_PROD  = TRIG_ITERATIONS + 2;
    localparam int S_POS   = TRIG_ITERATIONS + 3;
    localparam int S_DIV0  = TRIG_ITERATIONS + 4;
    localparam int S_FINAL = TRIG_ITERATIONS + 4 + QB;
    localparam int NS      = S_FINAL + 1;

    // Configuration registers.
    logic signed [23:0] centre_x_reg, centre_y_reg, centre_z_reg;
    logic [22:0]        radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTRE_X: centre_x_reg <= cfg_data;
                REG_CENTRE_Y: centre_y_reg <= cfg_data;
                REG_CENTRE_Z: centre_z_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[22:0];
                default:      ;
            endcase
        end
    end

    // Pipeline registers and handshake chain.
    stage_t        data_reg [NS];
    stage_t        data_next [NS];
    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;

    assign en[NS]    = vout.ready;
    assign vin.ready = en[0];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            // A stage may load when it is empty or its content moves on.
            assign en[s] = !valid_reg[s] || en[s+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (en[s])
                    valid_reg[s] <= (s == 0) ? vin.valid : valid_reg[(s == 0) ? 0 : s-1];
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                    data_reg[s] <= data_next[s];
            end

            if (s == 0)
            begin : g_entry
                // Place the angles in a full-turn word and fold to the nearest quadrant.
                always_comb
                begin
                    logic [47:0]      ext;
                    logic [2:0][31:0] ang;
                    logic [31:0]      qa;
                    logic [31:0]      resid;
                    data_next[s] = '0;
                    ext = {32'b0, vin.colatitude} << (32 - ANGLE_BITS);
                    ang[0] = ext[31:0];
                    ext = {32'b0, vin.longitude} << (32 - ANGLE_BITS);
                    ang[1] = ext[31:0];
                    ang[2] = ang[0] >> 1;
                    for (int u = 0; u < 3; u++)
                    begin
                        qa = ang[u] + 32'h2000_0000;
                        resid = ang[u] - {qa[31:30], 30'b0};
                        data_next[s].quad[u] = qa[31:30];
                        data_next[s].cz[u]   = {{(CW-32){resid[31]}}, resid};
                        data_next[s].cx[u]   = CORDIC_GAIN;
                        data_next[s].cy[u]   = '0;
                    end
                    data_next[s].lu = vin.local_u;
                    data_next[s].lv = vin.local_v;
                end
            end
            else if (s <= TRIG_ITERATIONS)
            begin : g_rot
                // One rotation step for each of the three units.
                always_comb
                begin
                    logic signed [CW-1:0] x, y, z, dx, dy;
                    data_next[s] = data_reg[s-1];
                    for (int u = 0; u < 3; u++)
                    begin
                        x = $signed(data_reg[s-1].cx[u]);
                        y = $signed(data_reg[s-1].cy[u]);
                        z = $signed(data_reg[s-1].cz[u]);
                        dx = y >>> (s - 1);
                        dy = x >>> (s - 1);
                        if (!z[CW-1])
                        begin
                            data_next[s].cx[u] = x - dx;
                            data_next[s].cy[u] = y + dy;
                            data_next[s].cz[u] = z - atan_step(s - 1);
                        end
                        else
                        begin
                            data_next[s].cx[u] = x + dx;
                            data_next[s].cy[u] = y - dy;
                            data_next[s].cz[u] = z + atan_step(s - 1);
                        end
                    end
                end
            end
            else if (s == S_TRIG)
            begin : g_trig
                // Undo the quadrant fold and round sine and cosine to Q1.15.
                always_comb
                begin
                    logic signed [CW-1:0] x, y, c, sn;
                    logic signed [47:0]   w;
                    data_next[s] = data_reg[s-1];
                    for (int u = 0; u < 3; u++)
                    begin
                        x = $signed(data_reg[s-1].cx[u]);
                        y = $signed(data_reg[s-1].cy[u]);
                        unique case (data_reg[s-1].quad[u])
                            2'd0:    begin c = x;  sn = y;  end
                            2'd1:    begin c = -y; sn = x;  end
                            2'd2:    begin c = -x; sn = -y; end
                            default: begin c = y;  sn = -x; end
                        endcase
                        w = 48'(sn);
                        data_next[s].trig[2*u]   = sat16(rnd15(w));
                        w = 48'(c);
                        data_next[s].trig[2*u+1] = sat16(rnd15(w));
                    end
                end
            end
            else if (s == S_PROD)
            begin : g_prod
                // Normal products and the disk radius division setup.
                always_comb
                begin
                    logic signed [15:0] st, ct, sl, cl, sh, ch;
                    logic signed [31:0] m;
                    logic signed [47:0] w;
                    logic [16:0]        ash, ach;
                    logic [33:0]        num;
                    logic [39:0]        lim;
                    data_next[s] = data_reg[s-1];
                    st = $signed(data_reg[s-1].trig[0]);
                    ct = $signed(data_reg[s-1].trig[1]);
                    sl = $signed(data_reg[s-1].trig[2]);
                    cl = $signed(data_reg[s-1].trig[3]);
                    sh = $signed(data_reg[s-1].trig[4]);
                    ch = $signed(data_reg[s-1].trig[5]);
                    m = st * cl;
                    w = 48'(m);
                    data_next[s].nx = sat16(rnd15(w));
                    m = st * sl;
                    w = 48'(m);
                    data_next[s].nz = sat16(rnd15(w));
                    data_next[s].ny = ct;
                    ash = sh[15] ? 17'(-{sh[15], sh}) : {1'b0, sh};
                    ach = ch[15] ? 17'(-{ch[15], ch}) : {1'b0, ch};
                    num = {ash, 17'b0};
                    lim = {ach, 23'b0} - {23'b0, ach};
                    data_next[s].den  = ach;
                    data_next[s].clip = (ach == 17'd0) || ({6'b0, num} > lim);
                    data_next[s].neg  = sh[15] != ch[15];
                    data_next[s].rem  = {1'b0, num} + {19'b0, ach[16:1]};
                    data_next[s].quo  = '0;
                end
            end
            else if (s == S_POS)
            begin : g_pos
                // Position: centre plus radius times normal, saturated.
                always_comb
                begin
                    logic signed [23:0] rad;
                    logic signed [39:0] p;
                    logic signed [47:0] w;
                    logic signed [47:0] cen;
                    data_next[s] = data_reg[s-1];
                    rad = $signed({1'b0, radius_reg});
                    p = rad * $signed(data_reg[s-1].nx);
                    w = 48'(p);
                    cen = 48'(centre_x_reg);
                    data_next[s].px = sat24(rnd15(w) + cen);
                    p = rad * $signed(data_reg[s-1].ny);
                    w = 48'(p);
                    cen = 48'(centre_y_reg);
                    data_next[s].py = sat24(rnd15(w) + cen);
                    p = rad * $signed(data_reg[s-1].nz);
                    w = 48'(p);
                    cen = 48'(centre_z_reg);
                    data_next[s].pz = sat24(rnd15(w) + cen);
                end
            end
            else if (s < S_FINAL)
            begin : g_div
                // One restoring divider step, most significant quotient bit first.
                always_comb
                begin
                    logic [39:0] dsh;
                    data_next[s] = data_reg[s-1];
                    dsh = {23'b0, data_reg[s-1].den} << (QB - 1 - (s - S_DIV0));
                    if ({5'b0, data_reg[s-1].rem} >= dsh)
                    begin
                        data_next[s].rem = data_reg[s-1].rem - dsh[RW-1:0];
                        data_next[s].quo[QB - 1 - (s - S_DIV0)] = 1'b1;
                    end
                end
            end
            else
            begin : g_final
                // Disk coordinate: signed radius times sin l and times -cos l.
                always_comb
                begin
                    logic signed [23:0] r, nr;
                    logic signed [39:0] p;
                    logic signed [47:0] w;
                    data_next[s] = data_reg[s-1];
                    r = data_reg[s-1].clip ? Q716_MAX : $signed({1'b0, data_reg[s-1].quo});
                    if (data_reg[s-1].neg)
                        r = -r;
                    nr = -r;
                    p = r * $signed(data_reg[s-1].trig[2]);
                    w = 48'(p);
                    data_next[s].du = sat24(rnd15(w));
                    p = nr * $signed(data_reg[s-1].trig[3]);
                    w = 48'(p);
                    data_next[s].dv = sat24(rnd15(w));
                end
            end
        end
    endgenerate

    // Output register is the last stage.
    assign vout.valid          = valid_reg[NS-1];
    assign vout.pos_x          = data_reg[NS-1].px;
    assign vout.pos_y          = data_reg[NS-1].py;
    assign vout.pos_z          = data_reg[NS-1].pz;
    assign vout.normal_x       = data_reg[NS-1].nx;
    assign vout.normal_y       = data_reg[NS-1].ny;
    assign vout.normal_z       = data_reg[NS-1].nz;
    assign vout.disk_u         = data_reg[NS-1].du;
    assign vout.disk_v         = data_reg[NS-1].dv;
    assign vout.tex_local_u    = data_reg[NS-1].lu;
    assign vout.tex_local_v    = data_reg[NS-1].lv;
    assign vout.disk_saturated = data_reg[NS-1].clip;

endmodule

`default_nettype wire

// ----- sim/svst_vertex_checker.sv -----
// Checker for the sphere vertex generator: predicts each vertex and compares transfers.
`timescale 1ns / 1ps

module svst_vertex_checker
    import svst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    svst_in_if          vin,
    svst_out_if         vout,
    output int          mismatches,
    output int          vertices_pending
);

    typedef struct packed {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [15:0] normal_z;
        logic [23:0] disk_u;
        logic [23:0] disk_v;
        logic        tex_local_u;
        logic        tex_local_v;
        logic        disk_saturated;
    } vertex_t;

    localparam longint DISK_MAX = 64'sd8388607;

    longint  centre_x_q;
    longint  centre_y_q;
    longint  centre_z_q;
    longint  radius_q;
    vertex_t expected_vertices[$];

    assign vertices_pending = expected_vertices.size();

    // Clamp a signed value to a two's complement width.
    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Drop 15 fraction bits, rounding half up.
    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    // Quadrant-reduced rotation giving sine and cosine in Q1.15.
    function automatic void trig_q15(input logic [31:0] ang, output longint s,
                                     output longint c);
        logic [31:0] quad;
        logic [31:0] resid;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      cx;
        longint      cy;
        quad  = ((ang + 32'h20000000) >> 30) & 32'd3;
        resid = ang - (quad << 30);
        z     = $signed(resid);
        x     = 64'sd652032874;
        y     = 0;
        for (int i = 0; i < TRIG_ITER_DEF && i < ATAN_N; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TABLE[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TABLE[i]);
            end
        end
        case (quad)
            32'd0:   begin cx = x;  cy = y;  end
            32'd1:   begin cx = -y; cy = x;  end
            32'd2:   begin cx = -x; cy = -y; end
            default: begin cx = y;  cy = -x; end
        endcase
        c = clamp_bits(round_q15(cx), 16);
        s = clamp_bits(round_q15(cy), 16);
    endfunction

    // Expected vertex for one sample point under the current registers.
    function automatic vertex_t predict_vertex(input logic [15:0] colat,
                                               input logic [15:0] lon,
                                               input logic lu, input logic lv);
        vertex_t     v;
        logic [31:0] t_ang;
        logic [31:0] l_ang;
        longint      st, ct, sl, cl, sh, ch, nx, nz, num, den, r;
        logic        clip;
        t_ang = {colat, 16'h0000};
        l_ang = {lon, 16'h0000};
        trig_q15(t_ang, st, ct);
        trig_q15(l_ang, sl, cl);
        trig_q15(t_ang >> 1, sh, ch);
        nx = clamp_bits(round_q15(st * cl), 16);
        nz = clamp_bits(round_q15(st * sl), 16);
        v.normal_x = nx[15:0];
        v.normal_y = ct[15:0];
        v.normal_z = nz[15:0];
        v.pos_x = 24'(clamp_bits(centre_x_q + round_q15(radius_q * nx), 24));
        v.pos_y = 24'(clamp_bits(centre_y_q + round_q15(radius_q * ct), 24));
        v.pos_z = 24'(clamp_bits(centre_z_q + round_q15(radius_q * nz), 24));
        // Disk radius 2 tan(t/2), clipped near the south pole.
        num  = 2 * (sh < 0 ? -sh : sh) * 65536;
        den  = ch < 0 ? -ch : ch;
        clip = (den == 0) || (num > DISK_MAX * den);
        r    = clip ? DISK_MAX : (num + den / 2) / den;
        if ((sh < 0) != (ch < 0))
            r = -r;
        v.disk_u         = 24'(clamp_bits(round_q15(r * sl), 24));
        v.disk_v         = 24'(clamp_bits(round_q15(-r * cl), 24));
        v.tex_local_u    = lu;
        v.tex_local_v    = lv;
        v.disk_saturated = clip;
        return v;
    endfunction

    // Register writes, predictions and comparisons, all on the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t got;
        vertex_t want;
        if (!rst_n)
        begin
            centre_x_q <= 0;
            centre_y_q <= 0;
            centre_z_q <= 0;
            radius_q   <= 117965;
            mismatches <= 0;
            expected_vertices.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CENTRE_X: centre_x_q <= longint'($signed(cfg_data));
                    REG_CENTRE_Y: centre_y_q <= longint'($signed(cfg_data));
                    REG_CENTRE_Z: centre_z_q <= longint'($signed(cfg_data));
                    REG_RADIUS:   radius_q   <= longint'(cfg_data[22:0]);
                    default:      ;
                endcase
            end
            if (vin.valid && vin.ready)
                expected_vertices.insert(expected_vertices.size(),
                                         predict_vertex(vin.colatitude, vin.longitude,
                                                        vin.local_u, vin.local_v));
            if (vout.valid && vout.ready)
            begin
                got = '{vout.pos_x, vout.pos_y, vout.pos_z, vout.normal_x, vout.normal_y,
                        vout.normal_z, vout.disk_u, vout.disk_v, vout.tex_local_u,
                        vout.tex_local_v, vout.disk_saturated};
                if (expected_vertices.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("vertex transfer with nothing expected: %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("vertex mismatch at %0t", $realtime);
                            $display("  pos    exp %h %h %h got %h %h %h", want.pos_x,
                                     want.pos_y, want.pos_z, got.pos_x, got.pos_y, got.pos_z);
                            $display("  normal exp %h %h %h got %h %h %h", want.normal_x,
                                     want.normal_y, want.normal_z, got.normal_x,
                                     got.normal_y, got.normal_z);
                            $display("  disk   exp %h %h %b got %h %h %b", want.disk_u,
                                     want.disk_v, want.disk_saturated, got.disk_u,
                                     got.disk_v, got.disk_saturated);
                            $display("  local  exp %b%b got %b%b", want.tex_local_u,
                                     want.tex_local_v, got.tex_local_u, got.tex_local_v);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/tb_sphere_vertex_stereo_texcoord.sv -----
// Testbench top of the sphere vertex generator: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_sphere_vertex_stereo_texcoord;
    import svst_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    int          mismatches;
    int          vertices_pending;
    int          cycle_count;
    bit          steady;
    bit          hold_output;

    svst_in_if  vin_ch();
    svst_out_if vout_ch();

    sphere_vertex_stereo_texcoord i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vin       (vin_ch),
        .vout      (vout_ch)
    );

    svst_vertex_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .vin              (vin_ch),
        .vout             (vout_ch),
        .mismatches       (mismatches),
        .vertices_pending (vertices_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One sample point: optional gap, then hold valid until the transfer.
    task automatic send_point(input logic [15:0] colat, input logic [15:0] lon,
                              input logic lu, input logic lv);
        int gap;
        gap = steady ? 0 : $urandom_range(13, 0);
        if (gap > 0)
        begin
            vin_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        vin_ch.colatitude = colat;
        vin_ch.longitude  = lon;
        vin_ch.local_u    = lu;
        vin_ch.local_v    = lv;
        vin_ch.valid      = 1'b1;
        do @(posedge clk); while (!vin_ch.ready);
        @(negedge clk);
    endtask

    // Wait until every vertex is out, then for the pipeline latency.
    task automatic drain_pipeline();
        vin_ch.valid = 1'b0;
        wait (vertices_pending == 0);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random point: mostly the valid colatitude range, some near the south pole, some full-width angles.
    task automatic send_random_points(input int count);
        logic [15:0] colat;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3, 0) == 0)
                colat = 16'($urandom_range(65535, 0));
            else if ($urandom_range(7, 0) == 0)
                colat = 16'(32768 - $urandom_range(40, 0));
            else
                colat = 16'($urandom_range(32768, 0));
            send_point(colat, 16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)),
                       1'($urandom_range(1, 0)));
        end
    endtask

    // Receiver: random stalls, with one long hold-off.
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        vout_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_output && !held)
            begin
                vout_ch.ready = 1'b0;
                repeat (300) @(negedge clk);
                held = 1'b1;
            end
            gap = steady ? 0 : $urandom_range(13, 0);
            if (gap > 0)
            begin
                vout_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            vout_ch.ready = 1'b1;
            do @(posedge clk); while (!vout_ch.valid);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [15:0] corner_colat [9];
        logic [15:0] corner_lon [5];
        corner_colat = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768, 16'd32760,
                         16'd49152, 16'd65535, 16'd40000};
        corner_lon   = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
        steady           = 1'b0;
        hold_output      = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_CENTRE_X;
        cfg_data         = '0;
        vin_ch.valid      = 1'b0;
        vin_ch.colatitude = '0;
        vin_ch.longitude  = '0;
        vin_ch.local_u    = 1'b0;
        vin_ch.local_v    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners under the reset registers: poles, equator, wrap.
        for (int k = 0; k < 9; k++)
            send_point(corner_colat[k], corner_lon[k % 5], k[0], k[1]);
        for (int k = 0; k < 5; k++)
            send_point(16'd24576, corner_lon[k], k[1], k[0]);
        send_random_points(200);
        drain_pipeline();

        // Extreme positive centre and largest radius, with a long output stall.
        write_reg(REG_CENTRE_X, 24'h7FFFFF);
        write_reg(REG_CENTRE_Y, 24'h7FFFFF);
        write_reg(REG_CENTRE_Z, 24'h7FFFFF);
        write_reg(REG_RADIUS, 24'h7FFFFF);
        hold_output = 1'b1;
        steady      = 1'b1;
        send_random_points(150);
        steady = 1'b0;
        send_random_points(100);
        drain_pipeline();

        // Extreme negative centre and zero radius.
        write_reg(REG_CENTRE_X, 24'h800000);
        write_reg(REG_CENTRE_Y, 24'h800000);
        write_reg(REG_CENTRE_Z, 24'h800000);
        write_reg(REG_RADIUS, 24'h000000);
        send_random_points(200);
        drain_pipeline();

        // Negative extremes with the largest radius.
        write_reg(REG_RADIUS, 24'hFFFFFF);
        send_random_points(200);
        drain_pipeline();

        // Random settings.
        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_CENTRE_X, 24'($urandom_range(24'hFFFFFF, 0)));
            write_reg(REG_CENTRE_Y, 24'($urandom_range(24'hFFFFFF, 0)));
            write_reg(REG_CENTRE_Z, 24'($urandom_range(24'hFFFFFF, 0)));
            write_reg(REG_RADIUS, 24'($urandom_range(24'hFFFFFF, 0)));
            steady = (p == 1);
            send_random_points(120);
            steady = 1'b0;
            drain_pipeline();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
